/* hdl/fat_next_fit_allocator_defines.svh */
// Assertion macros shared by the allocator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef FAT_NEXT_FIT_ALLOCATOR_DEFINES_SVH
`define FAT_NEXT_FIT_ALLOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define FAT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define FAT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/fat_pkg.sv */
`timescale 1ns / 1ps

package fat_pkg;

	// Table geometry. Entries are always 16 bits wide, whatever the table depth.
	localparam int INDEX_BITS = 16;
	localparam int FIELD_W    = 16;
	localparam int CNT_W      = INDEX_BITS + 1;
	localparam int TABLE_SIZE = 1 << INDEX_BITS;

	localparam logic [INDEX_BITS-1:0] LAST_INDEX  = INDEX_BITS'(TABLE_SIZE - 1);
	localparam logic [INDEX_BITS-1:0] FIRST_INDEX = INDEX_BITS'(1);

	localparam logic [FIELD_W-1:0] END_MARK  = 16'hFFFF;
	localparam logic [FIELD_W-1:0] FREE_MARK = 16'h0000;

	// Request codes.
	localparam logic [1:0] REQ_ALLOC = 2'd0;
	localparam logic [1:0] REQ_FREE  = 2'd1;
	localparam logic [1:0] REQ_LINK  = 2'd2;

	// Status codes.
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_FULL = 2'd1;
	localparam logic [1:0] STAT_BAD  = 2'd2;

	// True for an index that names a usable table entry.
	function automatic logic in_range(input logic [FIELD_W-1:0] v);
		in_range = (v != FREE_MARK) && (32'(v) < 32'(TABLE_SIZE));
	endfunction

endpackage

/* hdl/fat_next_fit_allocator.sv */
// File allocation table with next-fit allocation. The table holds 2^INDEX_BITS entries of
// 16 bits (0 = free, 0xFFFF = end of chain, anything else = index of the next entry), and
// entry 0 is never handed out. After reset the block runs a clearing pass that writes every
// entry to free, one entry a cycle, so it takes no request word until that pass is through.
// Each request word then gives exactly one response word. A link request, a bad request or
// a bad free start needs no table read. An allocate reads entries from the first scan
// position on and steps over every used entry until it finds a free one. A free clears the
// chain entry by entry, and stops on the end marker, a free entry, a broken link or the
// length limit. A full table is only reported once the scan has wrapped twice. The response
// register is loaded as the block goes back to idle, and the block never takes the next
// request word before that. The table memory has one read port and one write port, and one
// entry is examined a cycle. The block takes no new request while one is being worked on,
// but it does take one while the previous response still waits in the output register.
`timescale 1ns / 1ps

`include "fat_next_fit_allocator_defines.svh"

module fat_next_fit_allocator
	import fat_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,

	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         req_type,
	input  logic [FIELD_W-1:0] start_index,
	input  logic [FIELD_W-1:0] link_value,

	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] entry_index,
	output logic [FIELD_W-1:0] freed_count
);

	typedef enum logic [4:0] {
		S_CLEAR = 5'b00001,
		S_IDLE  = 5'b00010,
		S_ALLOC = 5'b00100,
		S_FREE  = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t                state_q, state_d;

	// ptr_q is the clearing address, the allocation scan pointer or the current chain entry,
	// depending on the state.
	logic [INDEX_BITS-1:0] ptr_q, ptr_d;
	logic [CNT_W-1:0]      cnt_q, cnt_d;
	logic                  wrap_q, wrap_d;
	logic [INDEX_BITS-1:0] scan_q, scan_d;

	logic [1:0]            res_status_q, res_status_d;
	logic [FIELD_W-1:0]    res_index_q, res_index_d;
	logic [FIELD_W-1:0]    res_freed_q, res_freed_d;

	logic                  rsp_valid_q;
	logic [1:0]            status_q;
	logic [FIELD_W-1:0]    entry_index_q;
	logic [FIELD_W-1:0]    freed_count_q;

	logic                  wr_en;
	logic [INDEX_BITS-1:0] wr_addr;
	logic [FIELD_W-1:0]    wr_data;
	logic [INDEX_BITS-1:0] rd_addr;
	logic [FIELD_W-1:0]    rd_data;

	logic [CNT_W-1:0]      inc_op;
	logic [CNT_W-1:0]      inc_sum;
	logic [INDEX_BITS-1:0] inc_idx;
	logic [INDEX_BITS-1:0] first_ptr;
	logic                  accept;
	logic                  out_free;

	fat_ram #(
		.WIDTH (FIELD_W),
		.DEPTH (TABLE_SIZE)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	// The one incrementer of the block. It advances the clearing address and the scan
	// pointer, forms the first scan position from the rolling pointer, and counts freed
	// entries.
	always_comb begin
		case (state_q)
			S_IDLE:  inc_op = CNT_W'(scan_q);
			S_FREE:  inc_op = cnt_q;
			default: inc_op = CNT_W'(ptr_q);
		endcase
	end

	assign inc_sum   = inc_op + CNT_W'(1);
	assign inc_idx   = inc_sum[INDEX_BITS-1:0];
	assign first_ptr = (scan_q == LAST_INDEX) ? FIRST_INDEX : inc_idx;

	always_comb begin
		state_d      = state_q;
		ptr_d        = ptr_q;
		cnt_d        = cnt_q;
		wrap_d       = wrap_q;
		scan_d       = scan_q;
		res_status_d = res_status_q;
		res_index_d  = res_index_q;
		res_freed_d  = res_freed_q;
		rd_addr      = ptr_q;
		wr_en        = 1'b0;
		wr_addr      = ptr_q;
		wr_data      = FREE_MARK;

		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
				if (ptr_q == LAST_INDEX) begin
					state_d = S_IDLE;
				end else begin
					ptr_d = inc_idx;
				end
			end

			S_IDLE: begin
				if (accept) begin
					res_index_d = start_index;
					res_freed_d = '0;
					case (req_type)
						REQ_ALLOC: begin
							rd_addr = first_ptr;
							ptr_d   = first_ptr;
							wrap_d  = 1'b0;
							state_d = S_ALLOC;
						end
						REQ_FREE: begin
							if (in_range(start_index)) begin
								rd_addr = start_index[INDEX_BITS-1:0];
								ptr_d   = start_index[INDEX_BITS-1:0];
								cnt_d   = '0;
								state_d = S_FREE;
							end else begin
								res_status_d = STAT_BAD;
								state_d      = S_DONE;
							end
						end
						REQ_LINK: begin
							if (in_range(start_index) &&
								(link_value == END_MARK || in_range(link_value))) begin
								wr_en        = 1'b1;
								wr_addr      = start_index[INDEX_BITS-1:0];
								wr_data      = link_value;
								res_status_d = STAT_OK;
							end else begin
								res_status_d = STAT_BAD;
							end
							state_d = S_DONE;
						end
						default: begin
							res_status_d = STAT_BAD;
							state_d      = S_DONE;
						end
					endcase
				end
			end

			S_ALLOC: begin
				if (rd_data == FREE_MARK) begin
					wr_en        = 1'b1;
					wr_data      = END_MARK;
					scan_d       = ptr_q;
					res_status_d = STAT_OK;
					res_index_d  = FIELD_W'(ptr_q);
					state_d      = S_DONE;
				end else if (ptr_q == LAST_INDEX) begin
					// Second wrap: every entry has been looked at and none is free.
					if (wrap_q) begin
						scan_d       = FIRST_INDEX;
						res_status_d = STAT_FULL;
						res_index_d  = '0;
						state_d      = S_DONE;
					end else begin
						wrap_d  = 1'b1;
						ptr_d   = FIRST_INDEX;
						rd_addr = FIRST_INDEX;
					end
				end else begin
					ptr_d   = inc_idx;
					rd_addr = inc_idx;
				end
			end

			S_FREE: begin
				if (rd_data == FREE_MARK || cnt_q[INDEX_BITS]) begin
					res_status_d = STAT_BAD;
					res_freed_d  = FIELD_W'(cnt_q);
					state_d      = S_DONE;
				end else begin
					wr_en       = 1'b1;
					cnt_d       = inc_sum;
					res_freed_d = FIELD_W'(inc_sum);
					if (rd_data == END_MARK) begin
						res_status_d = STAT_OK;
						state_d      = S_DONE;
					end else if (!in_range(rd_data) || rd_data == FIELD_W'(ptr_q)) begin
						// An entry that points at itself would next be read just as it is
						// cleared; it is a broken chain either way.
						res_status_d = STAT_BAD;
						state_d      = S_DONE;
					end else begin
						ptr_d   = rd_data[INDEX_BITS-1:0];
						rd_addr = rd_data[INDEX_BITS-1:0];
					end
				end
			end

			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			ptr_q       <= '0;
			cnt_q       <= '0;
			wrap_q      <= 1'b0;
			scan_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ptr_q   <= ptr_d;
			cnt_q   <= cnt_d;
			wrap_q  <= wrap_d;
			scan_q  <= scan_d;
			if (state_q == S_DONE && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Result words carry no reset; they are only looked at while the valid flag is set.
	always_ff @(posedge clk) begin
		res_status_q <= res_status_d;
		res_index_q  <= res_index_d;
		res_freed_q  <= res_freed_d;
		if (state_q == S_DONE && out_free) begin
			status_q      <= res_status_q;
			entry_index_q <= res_index_q;
			freed_count_q <= res_freed_q;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign entry_index = entry_index_q;
	assign freed_count = freed_count_q;

	`FAT_ASSERT_SAME(a_no_req_while_clearing, state_q == S_CLEAR, req_stall,
		"request word taken during the clearing pass")
	`FAT_ASSERT_SAME(a_full_word_empty, rsp_valid && status == STAT_FULL,
		entry_index == '0 && freed_count == '0, "table-full response carries a payload")
	`FAT_ASSERT_NEXT(a_done_hands_over, state_q == S_DONE && out_free,
		rsp_valid_q && state_q == S_IDLE, "finished result not moved to the output")

endmodule

/* hdl/fat_ram.sv */
`timescale 1ns / 1ps

module fat_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

/* bench/fat_next_fit_allocator_test.sv */
`timescale 1ns / 1ps

module fat_next_fit_allocator_test
	import fat_pkg::*;
();

	// Request code that the block has no name for; it must answer it as a bad request.
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	// Hard stop for a hung run. Scans only step over the few entries in use ahead of the
	// pointer, and chains are short.
	localparam int CYCLE_LIMIT = 6_000_000;

	typedef struct packed {
		logic [1:0]         status;
		logic [FIELD_W-1:0] entry;
		logic [FIELD_W-1:0] freed;
	} reply_t;

	// Shadow copy of the allocation table and of the rolling scan pointer. Every accepted
	// request word updates it and queues the response word that the block owes for it.
	class fat_mirror;
		bit [FIELD_W-1:0]   entries [TABLE_SIZE];
		logic [FIELD_W-1:0] roving_ptr;
		reply_t             awaited[$];
		int                 failures;

		function new();
			roving_ptr = '0;
			failures   = 0;
		endfunction

		function bit usable_index(int unsigned v);
			return v != 0 && v < TABLE_SIZE;
		endfunction

		// Next-fit search; the second wrap past the top of the table means it is full.
		function logic [FIELD_W-1:0] mirror_alloc(output logic [1:0] st);
			int unsigned probe;
			int unsigned laps;
			probe = int'(roving_ptr) + 1;
			laps  = 0;
			if (probe >= TABLE_SIZE)
				probe = 1;
			while (entries[probe] != FREE_MARK) begin
				probe++;
				if (probe >= TABLE_SIZE) begin
					probe = 1;
					laps++;
					if (laps >= 2) begin
						roving_ptr = FIRST_INDEX;
						st = STAT_FULL;
						return '0;
					end
				end
			end
			roving_ptr     = probe[FIELD_W-1:0];
			entries[probe] = END_MARK;
			st = STAT_OK;
			return probe[FIELD_W-1:0];
		endfunction

		// Walks the chain, clearing as it goes. Entries cleared before a fault stay cleared.
		function int unsigned mirror_free(logic [FIELD_W-1:0] start, output logic [1:0] st);
			int unsigned        cur;
			int unsigned        count;
			bit [FIELD_W-1:0]   nxt;
			bit                 busy;
			st    = STAT_BAD;
			count = 0;
			cur   = start;
			busy  = usable_index(start);
			while (busy) begin
				nxt = entries[cur];
				if (nxt == FREE_MARK || count >= TABLE_SIZE) begin
					busy = 0;
				end else begin
					entries[cur] = FREE_MARK;
					count++;
					if (nxt == END_MARK) begin
						st   = STAT_OK;
						busy = 0;
					end else if (!usable_index(nxt)) begin
						busy = 0;
					end else begin
						cur = nxt;
					end
				end
			end
			return count;
		endfunction

		function reply_t note_request(logic [1:0] kind, logic [FIELD_W-1:0] idx,
				logic [FIELD_W-1:0] lnk);
			reply_t     r;
			logic [1:0] st;
			r.status = STAT_BAD;
			r.entry  = idx;
			r.freed  = '0;
			case (kind)
			REQ_ALLOC: begin
				r.entry  = mirror_alloc(st);
				r.status = st;
			end
			REQ_FREE: begin
				r.freed  = FIELD_W'(mirror_free(idx, st));
				r.status = st;
			end
			REQ_LINK: begin
				if (usable_index(idx) && (lnk == END_MARK || usable_index(lnk))) begin
					entries[idx] = lnk;
					r.status = STAT_OK;
				end
			end
			default: begin
			end
			endcase
			awaited.push_back(r);
			return r;
		endfunction

		function void check_response(logic [1:0] st, logic [FIELD_W-1:0] ent,
				logic [FIELD_W-1:0] frd);
			reply_t want;
			if (awaited.size() == 0) begin
				failures++;
				if (failures <= 10)
					$display("unexpected response word: status %0d entry %0d freed %0d",
						st, ent, frd);
			end else begin
				want = awaited.pop_front();
				if (st !== want.status || ent !== want.entry || frd !== want.freed) begin
					failures++;
					if (failures <= 10)
						$display("mismatch: expected status %0d entry %0d freed %0d, %s %0d %0d %0d",
							want.status, want.entry, want.freed,
							"got status/entry/freed", st, ent, frd);
				end
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [1:0]         req_type = REQ_ALLOC;
	logic [FIELD_W-1:0] start_index = '0;
	logic [FIELD_W-1:0] link_value = '0;
	logic               rsp_valid;
	logic               rsp_stall = 1'b0;
	logic [1:0]         status;
	logic [FIELD_W-1:0] entry_index;
	logic [FIELD_W-1:0] freed_count;

	fat_mirror          fat_view;
	logic [FIELD_W-1:0] live_heads[$];
	int                 send_idle_pct = 0;
	int                 stall_pct = 0;
	int                 words_sent = 0;
	int                 cycle_count = 0;

	fat_next_fit_allocator DUT (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Response side. Outputs are sampled at the rising edge, before any of this edge's
	// updates land, and the stall for the next cycle is chosen in the same step.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			fat_view.check_response(status, entry_index, freed_count);
		rsp_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Presents one request word and returns once it has been taken, with the response
	// word that it should produce. Valid is left high on return, so a word that follows
	// at once keeps it high without a dip; an idle gap lowers it first.
	task automatic send_request(input logic [1:0] kind, input logic [FIELD_W-1:0] idx,
			input logic [FIELD_W-1:0] lnk, output reply_t got);
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid   <= 1'b1;
		req_type    <= kind;
		start_index <= idx;
		link_value  <= lnk;
		do
			@(posedge clk);
		while (req_stall);
		got = fat_view.note_request(kind, idx, lnk);
		words_sent++;
	endtask

	// Index for noisy words: mostly places where something is likely to be in use,
	// sometimes anything at all, sometimes the reserved entry or the top of the table.
	function automatic logic [FIELD_W-1:0] pick_index();
		case ($urandom_range(3))
		0:       return FIELD_W'($urandom_range(31));
		1:       return fat_view.roving_ptr + FIELD_W'($urandom_range(8));
		2:       return FIELD_W'($urandom_range(16'hFFFF));
		default: return ($urandom_range(1)) ? FREE_MARK : LAST_INDEX - FIELD_W'($urandom_range(1));
		endcase
	endfunction

	// Allocates len entries and links each to the next; the last keeps its end marker.
	task automatic build_chain(input int len, output logic [FIELD_W-1:0] head,
			output logic [FIELD_W-1:0] tail);
		reply_t r;
		reply_t lr;
		head = '0;
		tail = '0;
		for (int i = 0; i < len; i++) begin
			send_request(REQ_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom), r);
			if (i == 0)
				head = r.entry;
			else
				send_request(REQ_LINK, tail, r.entry, lr);
			tail = r.entry;
		end
	endtask

	// The opening words cover each request kind and several ways a request can go wrong.
	task automatic directed_checks();
		reply_t             r;
		logic [FIELD_W-1:0] a;
		logic [FIELD_W-1:0] b;
		// A two-entry chain from the first two allocations, freed whole.
		send_request(REQ_ALLOC, 16'h0000, 16'h0000, r);
		a = r.entry;
		send_request(REQ_ALLOC, 16'hFFFF, 16'hFFFF, r);
		send_request(REQ_LINK, a, r.entry, r);
		send_request(REQ_FREE, a, 16'h0000, r);
		// Freeing it again starts on a free entry; then the reserved entry as a start.
		send_request(REQ_FREE, a, 16'hFFFF, r);
		send_request(REQ_FREE, FREE_MARK, 16'hFFFF, r);
		// Links that must be refused: reserved entry as target and as successor.
		send_request(REQ_LINK, FREE_MARK, 16'd5, r);
		send_request(REQ_LINK, 16'd5, FREE_MARK, r);
		// The top entry of the table is a usable one.
		send_request(REQ_LINK, LAST_INDEX, END_MARK, r);
		send_request(REQ_FREE, LAST_INDEX, 16'h0000, r);
		send_request(REQ_UNUSED, 16'hFFFF, 16'hFFFF, r);
		send_request(REQ_UNUSED, 16'h0000, 16'h0000, r);
		// A chain that loops back on itself: the walk meets its own cleared head.
		send_request(REQ_ALLOC, 16'h0000, 16'h0000, r);
		a = r.entry;
		send_request(REQ_ALLOC, 16'h0000, 16'h0000, r);
		b = r.entry;
		send_request(REQ_LINK, a, b, r);
		send_request(REQ_LINK, b, a, r);
		send_request(REQ_FREE, a, 16'h0000, r);
		// A successor that was never allocated.
		send_request(REQ_ALLOC, 16'h0000, 16'h0000, r);
		a = r.entry;
		send_request(REQ_LINK, a, a + 16'd1, r);
		send_request(REQ_FREE, a, 16'h0000, r);
		// Two used entries just past the pointer, which the next allocation steps over.
		a = fat_view.roving_ptr;
		send_request(REQ_LINK, a + 16'd1, END_MARK, r);
		send_request(REQ_LINK, a + 16'd2, END_MARK, r);
		send_request(REQ_ALLOC, 16'h0000, 16'h0000, r);
	endtask

	// Mostly well-formed chains built and later freed, with broken chains, words that
	// fill entries ahead of the pointer, and some noise mixed in.
	task automatic random_traffic(input int count);
		reply_t             r;
		logic [FIELD_W-1:0] head;
		logic [FIELD_W-1:0] tail;
		logic [FIELD_W-1:0] a;
		int                 goal;
		int                 pick;
		int                 len;
		int                 k;
		goal = words_sent + count;
		while (words_sent < goal) begin
			pick = $urandom_range(99);
			if (pick < 38 || (pick < 60 && live_heads.size() == 0)) begin
				build_chain($urandom_range(6, 1), head, tail);
				live_heads.push_back(head);
			end else if (pick < 60) begin
				k = $urandom_range(live_heads.size() - 1);
				head = live_heads[k];
				live_heads.delete(k);
				send_request(REQ_FREE, head, FIELD_W'($urandom), r);
			end else if (pick < 68) begin
				len = $urandom_range(4, 1);
				for (int t = 1; t <= len; t++) begin
					a = fat_view.roving_ptr + FIELD_W'(t);
					if (a != FREE_MARK) begin
						send_request(REQ_LINK, a, END_MARK, r);
						live_heads.push_back(a);
					end
				end
				send_request(REQ_ALLOC, FIELD_W'($urandom), FIELD_W'($urandom), r);
				if (r.status == STAT_OK)
					live_heads.push_back(r.entry);
			end else if (pick < 78) begin
				build_chain($urandom_range(5, 2), head, tail);
				case ($urandom_range(2))
				0:       send_request(REQ_LINK, tail, head, r);
				1:       send_request(REQ_LINK, tail, pick_index(), r);
				default: send_request(REQ_FREE, head, 16'h0000, r);
				endcase
				send_request(REQ_FREE, head, FIELD_W'($urandom), r);
			end else if (pick < 92) begin
				send_request(2'($urandom_range(3)), pick_index(),
					($urandom_range(3) == 0) ? END_MARK : pick_index(), r);
			end else begin
				if ($urandom_range(1))
					send_request(REQ_LINK, FREE_MARK, pick_index(), r);
				else
					send_request(REQ_LINK, pick_index(), FREE_MARK, r);
			end
		end
	endtask

	initial begin
		fat_view = new();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// The block clears its table after reset and stalls requests meanwhile; the
		// first word simply waits for that to finish.
		directed_checks();

		// Random words in four settings of idling: none, the sender idle, the receiver
		// stalling, and both at once.
		random_traffic(490);
		send_idle_pct = 56;
		random_traffic(490);
		send_idle_pct = 0;
		stall_pct     = 56;
		random_traffic(490);
		send_idle_pct = 37;
		stall_pct     = 37;
		random_traffic(490);

		send_idle_pct = 0;
		stall_pct     = 0;
		req_valid <= 1'b0;

		while (fat_view.awaited.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (fat_view.failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
